### hw/rtl/ywac_pkg.sv
// Shared types, constants and fixed-point helpers for the Yule-Walker solver.
// No dependencies.
package ywac_pkg;

  localparam int MAX_ORDER = 32;
  localparam int LAG_W     = 32;
  localparam int FRAC      = 26;
  localparam int ORD_W     = 6;
  localparam int CIDX_W    = $clog2(MAX_ORDER);
  localparam int LIDX_W    = $clog2(MAX_ORDER + 1);
  localparam int ACC_W     = 48;
  localparam int DIV_STEPS = LAG_W + FRAC;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [ORD_W-1:0]  ORDER_RST = 6'd10;
  localparam logic signed [31:0] ONE_Q    = 32'sd67108864;
  localparam logic signed [31:0] S32_MAX  = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN  = 32'sh80000000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_UNSTABLE = 2'd2
  } status_t;

  // one queued lag item
  typedef struct packed {
    logic signed [31:0] lag;
    logic [LIDX_W-1:0]  idx;
    logic               last;
    logic [ORD_W-1:0]   order;
  } qent_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] num_mag;
    logic [31:0] den_mag;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = S32_MAX;
    else if (v < -48'sd2147483648) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Q52 product to Q26, round half up
  function automatic logic signed [ACC_W-1:0] rnd26(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd33554432;
    return ACC_W'(t >>> FRAC);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

### hw/rtl/ywac_front.sv
// Front end: order register, lag counter, tags each lag item for the queue.
// Depends on ywac_pkg.
module ywac_front import ywac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [ORD_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [LAG_W-1:0] in_lag_value,
  output logic                    q_push,
  output qent_t                   q_data,
  input  logic                    q_full
);

  logic [ORD_W-1:0]  order_r;
  logic [LIDX_W-1:0] cnt_r;
  logic              is_last;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_last  = (ORD_W'(cnt_r) == order_r);

  assign q_data.lag   = in_lag_value;
  assign q_data.idx   = cnt_r;
  assign q_data.last  = is_last;
  assign q_data.order = order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RST;
      cnt_r   <= '0;
    end else if (cfg_we) begin
      // partial frame dropped on a write
      if (cfg_data == '0) order_r <= ORD_W'(1);
      else if (cfg_data > ORD_W'(MAX_ORDER)) order_r <= ORD_W'(MAX_ORDER);
      else order_r <= cfg_data;
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= is_last ? '0 : cnt_r + LIDX_W'(1);
    end
  end

endmodule

### hw/rtl/ywac_queue.sv
// Two-entry queue between front end and solver.
// Depends on ywac_pkg.
module ywac_queue import ywac_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t head
);

  qent_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/ywac_div.sv
// Restoring divider: |num| * 2^26 / |den|, one quotient bit per cycle,
// truncated and saturated to signed 32 bits. Depends on ywac_pkg.
module ywac_div import ywac_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  div_req_t           req,
  output logic               done,
  output logic signed [31:0] quot
);

  logic                      busy_r, done_r, neg_r;
  logic [DCNT_W-1:0]         cnt_r;
  logic [DIV_STEPS-1:0]      dv_r;
  logic [31:0]               rem_r, den_r;
  logic [30:0]               q_r;
  logic signed [31:0]        res_r;
  logic [32:0]               trial;
  logic                      ge;
  logic [31:0]               rem_nxt;
  logic [30:0]               q_nxt;
  logic                      sat;

  assign sat     = {5'b0, req.num_mag} >= {req.den_mag, 5'b0};
  assign trial   = {rem_r, dv_r[DIV_STEPS-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
  assign q_nxt   = {q_r[29:0], ge};

  assign done = done_r;
  assign quot = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // saturated requests finish at once, others after the last step
      done_r <= req.start ? sat : (busy_r && cnt_r == DCNT_W'(DIV_STEPS - 1));
      if (req.start) begin
        if (sat) begin
          res_r  <= req.neg ? S32_MIN : S32_MAX;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          dv_r   <= {req.num_mag, {FRAC{1'b0}}};
          rem_r  <= '0;
          q_r    <= '0;
          neg_r  <= req.neg;
          den_r  <= req.den_mag;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        dv_r  <= dv_r << 1;
        cnt_r <= cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          res_r  <= neg_r ? -$signed({1'b0, q_nxt}) : $signed({1'b0, q_nxt});
        end
      end
    end
  end

endmodule

### hw/rtl/ywac_back.sv
// Solver back end: lag storage, normalization, Levinson-Durbin recursion on
// one shared multiplier and divider, and the output register.
// Depends on ywac_pkg and ywac_div.
module ywac_back import ywac_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  qent_t              q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ORD_W-1:0]   out_coef_index,
  output logic signed [31:0] out_coef_value,
  output logic               out_last_coef,
  output logic [1:0]         out_solve_status
);

  typedef enum logic [4:0] {
    S_IDLE, S_NRD, S_NST, S_NWT, S_ARD0, S_ALD, S_TRD, S_TMUL, S_TADD,
    S_KST, S_KWT, S_CRD, S_CWR, S_URD, S_UMUL, S_UWR,
    S_EMUL1, S_EOM, S_EMUL2, S_EUPD, S_ORD, S_OPUT
  } state_t;

  state_t                    state_r;
  logic [ORD_W-1:0]          order_r, m_r, valid_n_r;
  logic [LIDX_W-1:0]         i_r;
  logic signed [31:0]        r0_r, k_r, e_r, om_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [63:0]        prod_r;
  status_t                   status_r;

  logic signed [31:0] lag_mem  [MAX_ORDER+1];
  logic signed [31:0] norm_mem [MAX_ORDER+1];
  logic signed [31:0] coef_mem [MAX_ORDER];
  logic signed [31:0] prev_mem [MAX_ORDER];
  logic signed [31:0] lag_q, norm_q, coef_q, prev_qa, prev_qb;

  logic                 out_valid_r, out_last_r;
  logic [ORD_W-1:0]     out_idx_r;
  logic signed [31:0]   out_val_r;
  status_t              out_stat_r;

  logic [LIDX_W-1:0]    norm_ra;
  logic [CIDX_W-1:0]    coef_ra;
  logic                 coef_we;
  logic [CIDX_W-1:0]    coef_wa;
  logic signed [31:0]   coef_wd;
  logic signed [31:0]   mul_a, mul_b, acc_sat, upd_val, e_nxt;
  logic [LIDX_W-1:0]    m_ext, m_less1;
  logic                 out_free;
  div_req_t             div_req;
  logic                 div_done;
  logic signed [31:0]   div_q;

  ywac_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_q)
  );

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;
  assign m_ext    = LIDX_W'(m_r);
  assign m_less1  = m_ext - LIDX_W'(1);
  assign acc_sat  = sat32(acc_r);
  assign upd_val  = sat32(ACC_W'(prev_qa) + rnd26(prod_r));
  assign e_nxt    = sat32(rnd26(prod_r));

  always_comb begin
    norm_ra = (state_r == S_ARD0) ? m_ext : (m_ext - i_r);
    unique case (state_r)
      S_CRD:   coef_ra = CIDX_W'(i_r);
      default: coef_ra = CIDX_W'(i_r - LIDX_W'(1));
    endcase
    coef_we = 1'b0;
    coef_wa = CIDX_W'(i_r - LIDX_W'(1));
    coef_wd = upd_val;
    if (state_r == S_KWT && div_done) begin
      coef_we = 1'b1;
      coef_wa = CIDX_W'(m_less1);
      coef_wd = div_q;
    end else if (state_r == S_UWR) begin
      coef_we = 1'b1;
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      S_UMUL:  begin mul_a = k_r; mul_b = prev_qb; end
      S_EMUL1: begin mul_a = k_r; mul_b = k_r;     end
      S_EMUL2: begin mul_a = e_r; mul_b = om_r;    end
      default: begin mul_a = coef_q; mul_b = norm_q; end
    endcase
  end

  // shared divider: lag normalization or reflection coefficient
  always_comb begin
    div_req.start   = (state_r == S_NST) || (state_r == S_KST);
    if (state_r == S_KST) begin
      div_req.neg     = (acc_sat > 32'sd0);
      div_req.num_mag = abs32(acc_sat);
      div_req.den_mag = e_r;
    end else begin
      div_req.neg     = lag_q[31] ^ r0_r[31];
      div_req.num_mag = abs32(lag_q);
      div_req.den_mag = abs32(r0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) lag_mem[q_head.idx] <= q_head.lag;
    lag_q <= lag_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_NWT && div_done) norm_mem[i_r] <= div_q;
    norm_q <= norm_mem[norm_ra];
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_wa] <= coef_wd;
    coef_q <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CWR) prev_mem[CIDX_W'(i_r)] <= coef_q;
    prev_qa <= prev_mem[CIDX_W'(i_r - LIDX_W'(1))];
    prev_qb <= prev_mem[CIDX_W'(m_ext - i_r - LIDX_W'(1))];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      e_r         <= '0;
    end else begin
      // S_OPUT sets valid itself whenever the register is free
      if (out_valid_r && !out_stall && state_r != S_OPUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (q_head.idx == '0) r0_r <= q_head.lag;
            if (q_head.last) begin
              order_r <= q_head.order;
              if (r0_r == '0) begin
                status_r  <= ST_ZERO;
                valid_n_r <= '0;
                e_r       <= '0;
                i_r       <= LIDX_W'(1);
                state_r   <= S_ORD;
              end else begin
                i_r     <= '0;
                state_r <= S_NRD;
              end
            end
          end
        end
        S_NRD: state_r <= S_NST;
        S_NST: state_r <= S_NWT;
        S_NWT: begin
          if (div_done) begin
            if (i_r == LIDX_W'(order_r)) begin
              m_r     <= ORD_W'(1);
              e_r     <= ONE_Q;
              state_r <= S_ARD0;
            end else begin
              i_r     <= i_r + LIDX_W'(1);
              state_r <= S_NRD;
            end
          end
        end
        S_ARD0: state_r <= S_ALD;
        S_ALD: begin
          acc_r   <= ACC_W'(norm_q);
          i_r     <= LIDX_W'(1);
          state_r <= (m_r == ORD_W'(1)) ? S_KST : S_TRD;
        end
        S_TRD:  state_r <= S_TMUL;
        S_TMUL: state_r <= S_TADD;
        S_TADD: begin
          acc_r <= acc_r + rnd26(prod_r);
          if (i_r == m_less1) begin
            state_r <= S_KST;
          end else begin
            i_r     <= i_r + LIDX_W'(1);
            state_r <= S_TRD;
          end
        end
        S_KST: state_r <= S_KWT;
        S_KWT: begin
          if (div_done) begin
            k_r     <= div_q;
            i_r     <= '0;
            state_r <= (m_r == ORD_W'(1)) ? S_EMUL1 : S_CRD;
          end
        end
        S_CRD: state_r <= S_CWR;
        S_CWR: begin
          if (i_r == m_ext - LIDX_W'(2)) begin
            i_r     <= LIDX_W'(1);
            state_r <= S_URD;
          end else begin
            i_r     <= i_r + LIDX_W'(1);
            state_r <= S_CRD;
          end
        end
        S_URD:  state_r <= S_UMUL;
        S_UMUL: state_r <= S_UWR;
        S_UWR: begin
          if (i_r == m_less1) begin
            state_r <= S_EMUL1;
          end else begin
            i_r     <= i_r + LIDX_W'(1);
            state_r <= S_URD;
          end
        end
        S_EMUL1: state_r <= S_EOM;
        S_EOM: begin
          om_r    <= sat32(ACC_W'(ONE_Q) - rnd26(prod_r));
          state_r <= S_EMUL2;
        end
        S_EMUL2: state_r <= S_EUPD;
        S_EUPD: begin
          e_r <= e_nxt;
          if (e_nxt <= 32'sd0) begin
            status_r  <= ST_UNSTABLE;
            valid_n_r <= m_r;
            i_r       <= LIDX_W'(1);
            state_r   <= S_ORD;
          end else if (m_r == order_r) begin
            status_r  <= ST_OK;
            valid_n_r <= order_r;
            i_r       <= LIDX_W'(1);
            state_r   <= S_ORD;
          end else begin
            m_r     <= m_r + ORD_W'(1);
            state_r <= S_ARD0;
          end
        end
        S_ORD: state_r <= S_OPUT;
        S_OPUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= ORD_W'(i_r);
            out_val_r   <= (ORD_W'(i_r) <= valid_n_r) ? coef_q : '0;
            out_last_r  <= (ORD_W'(i_r) == order_r);
            out_stat_r  <= status_r;
            if (ORD_W'(i_r) == order_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + LIDX_W'(1);
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coef_index   = out_idx_r;
  assign out_coef_value   = out_val_r;
  assign out_last_coef    = out_last_r;
  assign out_solve_status = out_stat_r;

endmodule

### hw/rtl/yule_walker_ar_coefficients.sv
// Yule-Walker AR solver (Levinson-Durbin). Lags are taken one a cycle, unless
// in_stall is up, into a two-entry queue; a frame of P+1 lags is then normalized
// by the 58-step serial divider, and each order m runs a MAC loop, a divide for
// the reflection coefficient, a copy loop and an update loop, before the
// coefficients go out. The divider and the single multiplier set the pace.
// Synchronous active-low reset: order 10, empty queue, solver idle.
module yule_walker_ar_coefficients import ywac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [ORD_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [LAG_W-1:0] in_lag_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ORD_W-1:0]        out_coef_index,
  output logic signed [31:0]      out_coef_value,
  output logic                    out_last_coef,
  output logic [1:0]              out_solve_status
);

  // front -> queue
  logic  q_push, q_full, q_pop, q_empty;
  qent_t q_in, q_head;

  // Front: order register, lag counter, tags each item with index and
  // last-of-frame so the solver needs no knowledge of the register.
  ywac_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_lag_value(in_lag_value),
    .q_push      (q_push),
    .q_data      (q_in),
    .q_full      (q_full)
  );

  // Decoupling queue: lags keep flowing while the solver fetches.
  ywac_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: stores lags, solves on the last one, drives the output register.
  ywac_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coef_index  (out_coef_index),
    .out_coef_value  (out_coef_value),
    .out_last_coef   (out_last_coef),
    .out_solve_status(out_solve_status)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("queue overflow");

  // coefficient index stays within 1..MAX_ORDER
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coef_index != '0 && out_coef_index <= ORD_W'(MAX_ORDER)))
    else $error("coefficient index out of range");

  // zero-energy frames give only zero coefficients
  a_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_solve_status == ST_ZERO) |-> (out_coef_value == '0))
    else $error("nonzero coefficient on zero-energy frame");

endmodule

### verif/yule_walker_ar_coefficients_checker.sv
`timescale 1ns / 1ps
// Checker for the Yule-Walker AR solver: mirrors the order register and lag items,
// solves each frame by Levinson-Durbin in 64-bit fixed point and compares coefficients.
// Depends on ywac_pkg.
module yule_walker_ar_coefficients_checker import ywac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [ORD_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [LAG_W-1:0] in_lag_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [ORD_W-1:0]        out_coef_index,
  input  logic signed [31:0]      out_coef_value,
  input  logic                    out_last_coef,
  input  logic [1:0]              out_solve_status,
  output int                      pending,
  output int                      errors,
  output int                      checked
);

  typedef struct {
    logic [ORD_W-1:0]   idx;
    logic signed [31:0] val;
    logic               last;
    status_t            st;
  } coef_rec_t;

  coef_rec_t          coef_q[$];
  longint             frame_lags[0:MAX_ORDER];
  int                 lag_cnt;
  int                 order_p;
  int                 err_cnt;
  int                 chk_cnt;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q52 product back to Q26, round half up (arithmetic shift floors)
  function automatic longint q26_round(input longint p);
    return (p + 64'sd33554432) >>> FRAC;
  endfunction

  // num * 2^26 / den, truncated toward zero, saturated
  function automatic longint q26_ratio(input longint num, input longint den);
    longint unsigned a, b, q, r;
    bit neg;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    q = a / b;
    r = a % b;
    if (q >= 32) return neg ? -64'sd2147483648 : 64'sd2147483647;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic solve_frame(input int p);
    longint nrm[0:MAX_ORDER];
    longint cur[0:MAX_ORDER-1];
    longint prv[0:MAX_ORDER-1];
    longint err_e, acc, k, om;
    status_t st;
    coef_rec_t rec;
    for (int i = 0; i < MAX_ORDER; i++) cur[i] = 0;
    st = ST_OK;
    if (frame_lags[0] == 0) begin
      st = ST_ZERO;
    end else begin
      for (int i = 0; i <= p; i++) nrm[i] = q26_ratio(frame_lags[i], frame_lags[0]);
      err_e = 64'sd67108864;
      for (int m = 1; m <= p; m++) begin
        acc = nrm[m];
        for (int i = 1; i < m; i++) acc += q26_round(cur[i-1] * nrm[m-i]);
        acc = clamp32(acc);
        k = clamp32((-acc * 64'sd67108864) / err_e);
        prv = cur;
        cur[m-1] = k;
        for (int i = 1; i < m; i++) cur[i-1] = clamp32(prv[i-1] + q26_round(k * prv[m-i-1]));
        om = clamp32(64'sd67108864 - q26_round(k * k));
        err_e = clamp32(q26_round(err_e * om));
        if (err_e <= 0) begin
          st = ST_UNSTABLE;
          break;
        end
      end
    end
    for (int i = 1; i <= p; i++) begin
      rec.idx  = i[ORD_W-1:0];
      rec.val  = cur[i-1][31:0];
      rec.last = (i == p);
      rec.st   = st;
      coef_q.push_back(rec);
    end
  endtask

  always @(posedge clk) begin
    coef_rec_t exp_rec;
    int v;
    if (!rst_n) begin
      lag_cnt = 0;
      order_p = ORDER_RST;
      err_cnt = 0;
      chk_cnt = 0;
      coef_q.delete();
    end else begin
      if (cfg_we) begin
        v = cfg_data;
        if (v < 1) v = 1;
        if (v > MAX_ORDER) v = MAX_ORDER;
        order_p = v;
        lag_cnt = 0;  // partial frame dropped
      end
      if (in_valid && !in_stall) begin
        if (lag_cnt > order_p) lag_cnt = 0;
        frame_lags[lag_cnt] = in_lag_value;
        if (lag_cnt < order_p) lag_cnt++;
        else begin
          lag_cnt = 0;
          solve_frame(order_p);
        end
      end
      if (out_valid && !out_stall) begin
        chk_cnt++;
        if (coef_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected coefficient idx=%0d val=%0d", $realtime,
                     out_coef_index, out_coef_value);
        end else begin
          exp_rec = coef_q.pop_front();
          if (out_coef_index !== exp_rec.idx || out_coef_value !== exp_rec.val ||
              out_last_coef !== exp_rec.last || out_solve_status !== exp_rec.st) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: coef mismatch exp idx=%0d val=%0d last=%0b st=%0d",
                       $realtime, exp_rec.idx, exp_rec.val, exp_rec.last, exp_rec.st,
                       " got idx=%0d val=%0d last=%0b st=%0d", out_coef_index,
                       out_coef_value, out_last_coef, out_solve_status);
          end
        end
      end
    end
    pending <= coef_q.size();
    errors  <= err_cnt;
    checked <= chk_cnt;
  end

endmodule

### verif/yule_walker_ar_coefficients_tb.sv
`timescale 1ns / 1ps
// Top of the Yule-Walker solver testbench: clock, reset, lag frames and order writes.
// Depends on ywac_pkg, yule_walker_ar_coefficients and its checker module.
module yule_walker_ar_coefficients_tb;
  import ywac_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [ORD_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [LAG_W-1:0] in_lag_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ORD_W-1:0]        out_coef_index;
  logic signed [31:0]      out_coef_value;
  logic                    out_last_coef;
  logic [1:0]              out_solve_status;

  int pending, errors, checked;
  int send_idle_pct = 0;   // chance of a gap before each item
  int recv_stall_pct = 0;  // chance of out_stall each cycle
  int cur_order = ORDER_RST;
  int items_sent = 0;
  int frames_sent = 0;
  int max_order_seen = 0;
  longint cycles = 0;
  longint frame_buf[0:MAX_ORDER];

  localparam longint CYCLE_LIMIT = 3000000;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  yule_walker_ar_coefficients u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_lag_value(in_lag_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_coef_index(out_coef_index),
    .out_coef_value(out_coef_value), .out_last_coef(out_last_coef),
    .out_solve_status(out_solve_status)
  );

  yule_walker_ar_coefficients_checker u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_lag_value(in_lag_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_coef_index(out_coef_index),
    .out_coef_value(out_coef_value), .out_last_coef(out_last_coef),
    .out_solve_status(out_solve_status), .pending(pending), .errors(errors),
    .checked(checked)
  );

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog, sized for the slowest legal run with heavy stalls.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d coefficients outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One lag item; valid stays up across back-to-back items.
  task automatic send_lag(input longint v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_lag_value <= v[31:0];
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Solver budget for a frame of order p, with margin.
  function automatic int settle_cycles(input int p);
    return 70 * (p + 1) + 10 * p * p + 300;
  endfunction

  // Wait for every coefficient, then let the block go quiet before touching config.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle_cycles(cur_order)) @(posedge clk);
  endtask

  task automatic write_order(input int v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v[ORD_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_order = (v < 1) ? 1 : (v > MAX_ORDER) ? MAX_ORDER : v;
    if (cur_order > max_order_seen) max_order_seen = cur_order;
  endtask

  // Autocorrelation of a first-order filtered noise record: positive definite,
  // so the recursion usually runs all the way to order P.
  task automatic make_acf(input int p);
    longint x[0:39];
    longint a, amp, s;
    a   = $urandom_range(14) - 7;
    amp = longint'(1) << $urandom_range(9);
    x[0] = $urandom_range(2 * amp) - amp;
    for (int n = 1; n < 40; n++)
      x[n] = (x[n-1] * a) / 8 + longint'($urandom_range(2 * amp)) - amp;
    for (int k = 0; k <= p; k++) begin
      s = 0;
      for (int n = 0; n + k < 40; n++) s += x[n] * x[n+k];
      frame_buf[k] = s;
    end
  endtask

  task automatic send_frame(input int p);
    for (int i = 0; i <= p; i++) send_lag(frame_buf[i]);
    frames_sent++;
  endtask

  task automatic random_frame();
    int kind;
    kind = $urandom_range(99);
    make_acf(cur_order);
    if (kind >= 70 && kind < 80) begin
      for (int i = 0; i <= cur_order; i++) frame_buf[i] = longint'(signed'($urandom()));
    end else if (kind >= 80 && kind < 88) begin
      frame_buf[0] = 0;
    end else if (kind >= 88) begin
      // one lag disturbed: often drives the error to zero or saturates
      frame_buf[$urandom_range(cur_order)] = longint'(signed'($urandom()));
    end
    send_frame(cur_order);
  endtask

  int pick;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset order 10 with a clean frame.
    make_acf(10);
    send_frame(10);
    max_order_seen = 10;

    // Order 1 corner frames.
    write_order(1);
    frame_buf[0] = 0;           frame_buf[1] = 5;            send_frame(1);  // zero energy
    frame_buf[0] = 100;         frame_buf[1] = 100;          send_frame(1);  // error hits zero
    frame_buf[0] = -50;         frame_buf[1] = 20;           send_frame(1);  // negative r0
    frame_buf[0] = 1;           frame_buf[1] = 2147483647;   send_frame(1);  // ratio saturates
    frame_buf[0] = -2147483648; frame_buf[1] = 2147483647;   send_frame(1);  // extreme lags

    // Register value 0 clamps up to 1.
    write_order(0);
    frame_buf[0] = 7; frame_buf[1] = 3; send_frame(1);

    // Random part: short orders dominate, a few at the top of the range.
    while (items_sent < 240) begin
      if (items_sent < 100) begin
        send_idle_pct = 7;  recv_stall_pct = 48;
      end else if (items_sent < 190) begin
        send_idle_pct = 48; recv_stall_pct = 7;
      end else begin
        send_idle_pct = 0;  recv_stall_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 80)      write_order($urandom_range(6, 1));
      else if (pick < 92) write_order($urandom_range(16, 7));
      else if (pick < 96) write_order(MAX_ORDER);
      else                write_order($urandom_range(63, 33));  // clamps down
      repeat ($urandom_range(3, 1)) random_frame();
      // sometimes leave a partial frame for the next write to drop
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(cur_order)) send_lag(longint'(signed'($urandom())));
    end

    drain();
    $display("Covered %0d lag items in %0d frames, orders up to %0d, %0d coefficients checked.",
             items_sent, frames_sent, max_order_seen, checked);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d coefficients never seen", errors, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
